### rtl/hci_pkg.sv
// Shared types and constants for the HPGL command interpreter.
package hci_pkg;

	localparam int SCALE_W = 24;
	localparam int LIFT_W  = 16;
	localparam int LINE_W  = 16;
	localparam int CHAR_W  = 8;
	localparam int ACT_W   = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [SCALE_W-1:0] FEED_SCALE_RESET  = 24'd443897;
	localparam logic [LIFT_W-1:0]  INIT_LIFT_RESET   = 16'd1600;
	localparam logic [LIFT_W-1:0]  PEN_LIFT_RESET    = 16'd1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FEED_SCALE = 2'd0,
		CFG_INIT_LIFT  = 2'd1,
		CFG_PEN_LIFT   = 2'd2
	} cfg_index_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_MOVE  = 3'd0,
		ACT_LINE  = 3'd1,
		ACT_RAISE = 3'd2,
		ACT_LOWER = 3'd3,
		ACT_HOME  = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		PH_CMD       = 3'd0,
		PH_LETTER2   = 3'd1,
		PH_SP_ARG    = 3'd2,
		PH_ARG_START = 3'd3,
		PH_X_NUM     = 3'd4,
		PH_Y_NUM     = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		CMD_NONE = 3'd0,
		CMD_IN   = 3'd1,
		CMD_SP   = 3'd2,
		CMD_PU   = 3'd3,
		CMD_PD   = 3'd4,
		CMD_PA   = 3'd5,
		CMD_LT   = 3'd6
	} cmd_t;

	// Where the coordinates of a result come from.
	typedef enum logic [1:0] {
		SRC_ZERO = 2'd0,
		SRC_LAST = 2'd1,
		SRC_NEW  = 2'd2
	} xy_src_t;

	// Number flag bit positions.
	localparam int NF_DIG  = 0;
	localparam int NF_NEG  = 1;
	localparam int NF_FRAC = 2;
	localparam int NF_END  = 3;

	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_1     = 8'h31;
	localparam logic [CHAR_W-1:0] CH_8     = 8'h38;
	localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
	localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
	localparam logic [CHAR_W-1:0] CH_D     = 8'h44;
	localparam logic [CHAR_W-1:0] CH_I     = 8'h49;
	localparam logic [CHAR_W-1:0] CH_L     = 8'h4C;
	localparam logic [CHAR_W-1:0] CH_N     = 8'h4E;
	localparam logic [CHAR_W-1:0] CH_P     = 8'h50;
	localparam logic [CHAR_W-1:0] CH_S     = 8'h53;
	localparam logic [CHAR_W-1:0] CH_T     = 8'h54;
	localparam logic [CHAR_W-1:0] CH_U     = 8'h55;

	// Control part of a parsed plotter action.
	typedef struct packed {
		action_t            act;
		xy_src_t            src;
		logic [LIFT_W-1:0]  lift;
		logic [LINE_W-1:0]  line;
	} req_t;

endpackage

### rtl/hci_parser.sv
// Byte parser: mnemonic and number tracking, emits at most one action request per command.
module hci_parser #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid_s1,
	input  logic [hci_pkg::CHAR_W-1:0]    char_s1,
	input  logic                          take,
	input  logic                          lift_load,
	input  logic [hci_pkg::LIFT_W-1:0]    lift_value,
	input  logic [hci_pkg::LIFT_W-1:0]    pen_select_lift,
	output logic                          item_take,
	output logic                          req_valid_s2,
	output hci_pkg::req_t                 req_s2,
	output logic signed [COORD_BITS:0]    xv_s2,
	output logic signed [COORD_BITS:0]    yv_s2
);
	import hci_pkg::*;

	localparam int AW = COORD_BITS + 1;
	localparam int GW = COORD_BITS + 4;
	localparam logic signed [COORD_BITS:0] MAX_MAG = signed'(AW'(1) << (COORD_BITS - 1));
	localparam logic signed [COORD_BITS:0] TOP_VAL = MAX_MAG - AW'(1);
	localparam logic [GW-1:0] MAX_WIDE = GW'(1) << (COORD_BITS - 1);

	phase_t                     phase_q, phase_n;
	cmd_t                       cmd_q, cmd_n, cmd_dec;
	logic [CHAR_W-1:0]          held_q, held_n;
	logic signed [COORD_BITS:0] x_acc_q, x_n, y_acc_q, y_n;
	logic [3:0]                 flags_q, flags_n;
	logic                       pen_up_q, pen_up_n;
	logic [LIFT_W-1:0]          lift_q, lift_n;
	logic [LINE_W-1:0]          line_q, line_n;

	logic                       emit;
	req_t                       req_n;
	logic signed [COORD_BITS:0] xv_n, yv_n;

	logic                       is_digit, is_first, is_line_end;
	logic signed [COORD_BITS:0] feed_in, feed_acc;
	logic [3:0]                 feed_flags;
	logic [GW-1:0]              grown;

	logic                       comp_emit, comp_pen;
	action_t                    comp_act;
	xy_src_t                    comp_src;
	logic signed [COORD_BITS:0] comp_xv, comp_yv;

	function automatic logic signed [COORD_BITS:0] finish_value(
		input logic signed [COORD_BITS:0] mag,
		input logic                       neg
	);
		logic signed [COORD_BITS:0] r;
		if (neg) begin
			r = -mag;
		end else if (mag > TOP_VAL) begin
			r = TOP_VAL;
		end else begin
			r = mag;
		end
		return r;
	endfunction

	assign item_take = item_valid_s1 && (!req_valid_s2 || take);

	assign is_digit    = (char_s1 >= CH_0) && (char_s1 <= CH_9);
	assign is_first    = (char_s1 == CH_I) || (char_s1 == CH_S) || (char_s1 == CH_P) ||
		(char_s1 == CH_L);
	assign is_line_end = (char_s1 == CH_LF) || (char_s1 == CH_CR);

	// One character of a decimal number into the accumulator that is being built.
	always_comb begin
		feed_in    = (phase_q == PH_Y_NUM) ? y_acc_q : x_acc_q;
		feed_acc   = feed_in;
		feed_flags = flags_q;
		grown      = (GW'(feed_in[COORD_BITS-1:0]) << 3) + (GW'(feed_in[COORD_BITS-1:0]) << 1)
			+ GW'(char_s1 - CH_0);
		if (!flags_q[NF_END]) begin
			if (is_digit) begin
				if (!flags_q[NF_FRAC]) begin
					if (grown > MAX_WIDE) begin
						feed_acc = MAX_MAG;
					end else begin
						feed_acc = signed'({1'b0, grown[COORD_BITS-1:0]});
					end
				end
				feed_flags[NF_DIG] = 1'b1;
			end else if (char_s1 == CH_MINUS || char_s1 == CH_PLUS) begin
				if (flags_q[NF_DIG] || flags_q[NF_NEG] || flags_q[NF_FRAC]) begin
					feed_flags[NF_END] = 1'b1;
				end else if (char_s1 == CH_MINUS) begin
					feed_flags[NF_NEG] = 1'b1;
				end
			end else if (char_s1 == CH_DOT) begin
				if (flags_q[NF_FRAC]) begin
					feed_flags[NF_END] = 1'b1;
				end else begin
					feed_flags[NF_FRAC] = 1'b1;
				end
			end else begin
				feed_flags[NF_END] = 1'b1;
			end
		end
	end

	// What completing the pending command produces.
	always_comb begin
		comp_emit = 1'b0;
		comp_pen  = pen_up_q;
		comp_act  = ACT_LINE;
		comp_src  = SRC_ZERO;
		comp_xv   = '0;
		comp_yv   = '0;
		case (phase_q)
			PH_ARG_START: begin
				if (cmd_q == CMD_PU) begin
					if (!pen_up_q) begin
						comp_emit = 1'b1;
						comp_pen  = 1'b1;
						comp_act  = ACT_RAISE;
					end
				end else if (cmd_q == CMD_PD) begin
					if (pen_up_q) begin
						comp_emit = 1'b1;
						comp_pen  = 1'b0;
						comp_act  = ACT_LOWER;
					end
				end else begin
					comp_emit = 1'b1;
					comp_act  = ACT_LINE;
					comp_src  = SRC_LAST;
				end
			end
			PH_X_NUM: begin
				comp_emit = 1'b1;
				comp_act  = (cmd_q == CMD_PU) ? ACT_MOVE : ACT_LINE;
				comp_src  = SRC_NEW;
				comp_xv   = finish_value(x_acc_q, flags_q[NF_NEG]);
			end
			PH_Y_NUM: begin
				comp_emit = 1'b1;
				comp_act  = (cmd_q == CMD_PU) ? ACT_MOVE : ACT_LINE;
				comp_src  = SRC_NEW;
				comp_xv   = x_acc_q;
				comp_yv   = finish_value(y_acc_q, flags_q[NF_NEG]);
			end
			default: begin
				comp_emit = 1'b0;
			end
		endcase
	end

	always_comb begin
		cmd_dec = CMD_NONE;
		if (held_q == CH_I && char_s1 == CH_N) begin
			cmd_dec = CMD_IN;
		end else if (held_q == CH_S && char_s1 == CH_P) begin
			cmd_dec = CMD_SP;
		end else if (held_q == CH_P && char_s1 == CH_U) begin
			cmd_dec = CMD_PU;
		end else if (held_q == CH_P && char_s1 == CH_D) begin
			cmd_dec = CMD_PD;
		end else if (held_q == CH_P && char_s1 == CH_A) begin
			cmd_dec = CMD_PA;
		end else if (held_q == CH_L && char_s1 == CH_T) begin
			cmd_dec = CMD_LT;
		end
	end

	// Next parser state for the byte in the input register.
	always_comb begin
		phase_n  = phase_q;
		cmd_n    = cmd_q;
		held_n   = held_q;
		x_n      = x_acc_q;
		y_n      = y_acc_q;
		flags_n  = flags_q;
		pen_up_n = pen_up_q;
		lift_n   = lift_q;
		line_n   = line_q;
		emit     = 1'b0;
		req_n.act  = comp_act;
		req_n.src  = comp_src;
		req_n.lift = lift_q;
		req_n.line = line_q + LINE_W'(1);
		xv_n     = comp_xv;
		yv_n     = comp_yv;

		if (is_line_end) begin
			if (phase_q == PH_ARG_START || phase_q == PH_X_NUM || phase_q == PH_Y_NUM) begin
				emit     = comp_emit;
				pen_up_n = comp_pen;
			end
			// A LF directly after a CR belongs to the same line end.
			if (!(char_s1 == CH_LF && phase_q == PH_CMD && held_q == CH_CR)) begin
				line_n = line_q + LINE_W'(1);
			end
			phase_n = PH_CMD;
			held_n  = (char_s1 == CH_CR) ? CH_CR : '0;
		end else begin
			case (phase_q)
				PH_LETTER2: begin
					cmd_n = cmd_dec;
					case (cmd_dec)
						CMD_NONE: begin
							if (is_first) begin
								held_n = char_s1;
							end else begin
								held_n  = '0;
								phase_n = PH_CMD;
							end
						end
						CMD_SP: begin
							phase_n = PH_SP_ARG;
						end
						CMD_PU, CMD_PD, CMD_PA: begin
							phase_n = PH_ARG_START;
							x_n     = '0;
							y_n     = '0;
							flags_n = '0;
						end
						default: begin
							phase_n = PH_CMD;
						end
					endcase
				end
				PH_SP_ARG: begin
					if (char_s1 == CH_0) begin
						emit      = 1'b1;
						req_n.act = ACT_HOME;
						req_n.src = SRC_ZERO;
					end else if (char_s1 >= CH_1 && char_s1 <= CH_8) begin
						lift_n = pen_select_lift;
					end
					phase_n = PH_CMD;
				end
				PH_ARG_START: begin
					if (char_s1 == CH_SEMI) begin
						emit     = comp_emit;
						pen_up_n = comp_pen;
						phase_n  = PH_CMD;
					end else if (is_digit || char_s1 == CH_MINUS || char_s1 == CH_PLUS ||
						char_s1 == CH_DOT) begin
						phase_n = PH_X_NUM;
						x_n     = feed_acc;
						flags_n = feed_flags;
					end
				end
				PH_X_NUM: begin
					if (char_s1 == CH_SEMI) begin
						emit    = comp_emit;
						phase_n = PH_CMD;
					end else if (char_s1 == CH_SPACE || char_s1 == CH_COMMA) begin
						x_n     = finish_value(x_acc_q, flags_q[NF_NEG]);
						flags_n = '0;
						y_n     = '0;
						phase_n = PH_Y_NUM;
					end else begin
						x_n     = feed_acc;
						flags_n = feed_flags;
					end
				end
				PH_Y_NUM: begin
					if (char_s1 == CH_SEMI) begin
						emit    = comp_emit;
						phase_n = PH_CMD;
					end else if (!(char_s1 == CH_SPACE && flags_q == 4'd0)) begin
						y_n     = feed_acc;
						flags_n = feed_flags;
					end
				end
				default: begin
					if (is_first) begin
						held_n  = char_s1;
						phase_n = PH_LETTER2;
					end else begin
						held_n  = '0;
						phase_n = PH_CMD;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_CMD;
			cmd_q    <= CMD_NONE;
			held_q   <= '0;
			x_acc_q  <= '0;
			y_acc_q  <= '0;
			flags_q  <= '0;
			pen_up_q <= 1'b0;
			lift_q   <= INIT_LIFT_RESET;
			line_q   <= '0;
		end else if (lift_load) begin
			lift_q <= lift_value;
		end else if (item_take) begin
			phase_q  <= phase_n;
			cmd_q    <= cmd_n;
			held_q   <= held_n;
			x_acc_q  <= x_n;
			y_acc_q  <= y_n;
			flags_q  <= flags_n;
			pen_up_q <= pen_up_n;
			lift_q   <= lift_n;
			line_q   <= line_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s2 <= 1'b0;
		end else if (item_take) begin
			req_valid_s2 <= emit;
		end else if (take) begin
			req_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			req_s2 <= req_n;
			xv_s2  <= xv_n;
			yv_s2  <= yv_n;
		end
	end

endmodule

### rtl/hci_scaler.sv
// Output stage: scales coordinates to motor steps and holds the result register.
module hci_scaler #(
	parameter int COORD_BITS = 16,
	parameter int STEP_BITS  = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid_s2,
	input  hci_pkg::req_t                  req_s2,
	input  logic signed [COORD_BITS:0]     xv_s2,
	input  logic signed [COORD_BITS:0]     yv_s2,
	input  logic [hci_pkg::SCALE_W-1:0]    feed_scale,
	input  logic                           out_ready,
	output logic                           take,
	output logic                           out_valid,
	output logic [hci_pkg::ACT_W-1:0]      action,
	output logic signed [STEP_BITS-1:0]    x_steps,
	output logic signed [STEP_BITS-1:0]    y_steps,
	output logic [hci_pkg::LIFT_W-1:0]     lift_height,
	output logic [hci_pkg::LINE_W-1:0]     line_number
);
	import hci_pkg::*;

	localparam int PW = COORD_BITS + SCALE_W;
	localparam int QW = PW - 16;
	localparam int CW = ((QW > STEP_BITS) ? QW : STEP_BITS) + 1;
	localparam logic [CW-1:0] LIM = CW'(1) << (STEP_BITS - 1);

	logic signed [STEP_BITS-1:0] last_x_q, last_y_q;
	logic signed [STEP_BITS-1:0] new_x, new_y, sel_x, sel_y;

	// Truncate toward zero, then saturate to a signed step value.
	function automatic logic signed [STEP_BITS-1:0] to_steps(
		input logic signed [COORD_BITS:0] v,
		input logic [SCALE_W-1:0]         scale
	);
		logic                       neg;
		logic signed [COORD_BITS:0] av;
		logic [PW-1:0]              prod;
		logic [CW-1:0]              p;
		neg  = v[COORD_BITS];
		av   = neg ? -v : v;
		prod = PW'(av[COORD_BITS-1:0]) * PW'(scale);
		p    = CW'(prod[PW-1:16]);
		if (neg) begin
			if (p > LIM) begin
				p = LIM;
			end
			p = CW'(0) - p;
		end else if (p > LIM - CW'(1)) begin
			p = LIM - CW'(1);
		end
		return signed'(p[STEP_BITS-1:0]);
	endfunction

	assign new_x = to_steps(xv_s2, feed_scale);
	assign new_y = to_steps(yv_s2, feed_scale);
	assign take  = req_valid_s2 && (!out_valid || out_ready);

	always_comb begin
		case (req_s2.src)
			SRC_LAST: begin
				sel_x = last_x_q;
				sel_y = last_y_q;
			end
			SRC_NEW: begin
				sel_x = new_x;
				sel_y = new_y;
			end
			default: begin
				sel_x = '0;
				sel_y = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			last_x_q  <= '0;
			last_y_q  <= '0;
		end else begin
			if (take) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (take && req_s2.src == SRC_NEW) begin
				last_x_q <= new_x;
				last_y_q <= new_y;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			action      <= req_s2.act;
			x_steps     <= sel_x;
			y_steps     <= sel_y;
			lift_height <= req_s2.lift;
			line_number <= req_s2.line;
		end
	end

endmodule

### rtl/hpgl_command_interpreter.sv
// Top level of the HPGL command interpreter.
//
// Bytes of an HPGL stream arrive on the input channel (in_valid, in_ready,
// char_code), one byte per transfer. Each complete command yields zero or
// one plotter action on the output channel (out_valid, out_ready, action,
// x_steps, y_steps, lift_height, line_number).
// A byte goes through three registers: the input register, the parser's
// request register and the result register, which takes the output of the
// scaling multiply. The input register loads at the transfer edge, and the
// request and result registers follow in that order. Throughput is one byte
// per cycle while the receiver keeps up; each byte is a single state update
// of the parser, and the multiply that scales a coordinate pair has a stage
// of its own. When the receiver stalls, the result register holds its item
// and the stages behind it fill; in_ready drops only once all three are full.
// Reset clears the parser to its idle phase with the pen down and the line
// count at zero, empties all stages and loads the register defaults.
// Configuration writes take effect at once; the user makes them while idle,
// which the block does not enforce. A write of the initial lift height also
// sets the current lift height.
module hpgl_command_interpreter #(
	parameter int COORD_BITS = 16,
	parameter int STEP_BITS  = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [hci_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hci_pkg::SCALE_W-1:0]     cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [hci_pkg::CHAR_W-1:0]      char_code,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [hci_pkg::ACT_W-1:0]       action,
	output logic signed [STEP_BITS-1:0]     x_steps,
	output logic signed [STEP_BITS-1:0]     y_steps,
	output logic [hci_pkg::LIFT_W-1:0]      lift_height,
	output logic [hci_pkg::LINE_W-1:0]      line_number
);
	import hci_pkg::*;

	logic [SCALE_W-1:0]         feed_scale_q;
	logic [LIFT_W-1:0]          pen_lift_q;
	logic                       valid_s1;
	logic [CHAR_W-1:0]          char_s1;
	logic                       item_take, take, req_valid_s2, lift_load;
	req_t                       req_s2;
	logic signed [COORD_BITS:0] xv_s2, yv_s2;

	assign lift_load = cfg_write_en && (cfg_index == CFG_INIT_LIFT);
	assign in_ready  = !valid_s1 || item_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_scale_q <= FEED_SCALE_RESET;
			pen_lift_q   <= PEN_LIFT_RESET;
		end else if (cfg_write_en) begin
			if (cfg_index == CFG_FEED_SCALE) begin
				feed_scale_q <= cfg_wdata;
			end else if (cfg_index == CFG_PEN_LIFT) begin
				pen_lift_q <= cfg_wdata[LIFT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
		end
	end

	hci_parser #(
		.COORD_BITS(COORD_BITS)
	) u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid_s1  (valid_s1),
		.char_s1        (char_s1),
		.take           (take),
		.lift_load      (lift_load),
		.lift_value     (cfg_wdata[LIFT_W-1:0]),
		.pen_select_lift(pen_lift_q),
		.item_take      (item_take),
		.req_valid_s2   (req_valid_s2),
		.req_s2         (req_s2),
		.xv_s2          (xv_s2),
		.yv_s2          (yv_s2)
	);

	hci_scaler #(
		.COORD_BITS(COORD_BITS),
		.STEP_BITS (STEP_BITS)
	) u_scaler (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid_s2(req_valid_s2),
		.req_s2      (req_s2),
		.xv_s2       (xv_s2),
		.yv_s2       (yv_s2),
		.feed_scale  (feed_scale_q),
		.out_ready   (out_ready),
		.take        (take),
		.out_valid   (out_valid),
		.action      (action),
		.x_steps     (x_steps),
		.y_steps     (y_steps),
		.lift_height (lift_height),
		.line_number (line_number)
	);

endmodule

### bench/hpgl_command_interpreter_tb.sv
// Self-checking testbench for the HPGL command interpreter: byte stream in, plotter actions out.
module hpgl_command_interpreter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hci_pkg::*;

	localparam int     STEP_W     = 24;
	localparam longint COORD_MAG  = 64'sd32768;
	localparam int     IDLE_LIMIT = 2000;
	localparam int     NUM_PHASES = 6;
	localparam int     PER_PHASE  = 245;
	localparam int     SETTLE     = 8;

	typedef struct {
		logic [ACT_W-1:0]  act;
		logic [STEP_W-1:0] xs;
		logic [STEP_W-1:0] ys;
		logic [LIFT_W-1:0] lift;
		logic [LINE_W-1:0] line;
	} plot_action_t;

	// Tracks the interpreter state byte by byte and holds the actions it must emit.
	class plot_action_checker;
		logic [SCALE_W-1:0] feed_scale;
		logic [LIFT_W-1:0]  init_lift;
		logic [LIFT_W-1:0]  pen_lift;
		logic [LIFT_W-1:0]  cur_lift;
		phase_t             phase;
		cmd_t               cmd;
		logic [CHAR_W-1:0]  held;
		longint             x_acc;
		longint             y_acc;
		logic [3:0]         flags;
		bit                 pen_up;
		logic [STEP_W-1:0]  last_x;
		logic [STEP_W-1:0]  last_y;
		logic [LINE_W-1:0]  line_count;
		plot_action_t       expected_actions[$];
		int                 errors;
		int                 bytes_seen;
		int                 actions_seen;
		int                 act_count[5];

		function new();
			feed_scale = FEED_SCALE_RESET;
			init_lift = INIT_LIFT_RESET;
			pen_lift = PEN_LIFT_RESET;
			cur_lift = INIT_LIFT_RESET;
			phase = PH_CMD;
			cmd = CMD_NONE;
			held = '0;
			x_acc = 0;
			y_acc = 0;
			flags = '0;
			pen_up = 1'b0;
			last_x = '0;
			last_y = '0;
			line_count = '0;
			errors = 0;
			bytes_seen = 0;
			actions_seen = 0;
			foreach (act_count[i]) act_count[i] = 0;
		endfunction

		function void apply_config(cfg_index_t idx, logic [SCALE_W-1:0] value);
			case (idx)
			CFG_FEED_SCALE: feed_scale = value;
			CFG_INIT_LIFT: begin
				init_lift = value[LIFT_W-1:0];
				cur_lift = value[LIFT_W-1:0];
			end
			CFG_PEN_LIFT: pen_lift = value[LIFT_W-1:0];
			default: ;
			endcase
		endfunction

		function int pending();
			return expected_actions.size();
		endfunction

		function bit first_letter(logic [CHAR_W-1:0] c);
			return c == CH_I || c == CH_S || c == CH_P || c == CH_L;
		endfunction

		function void emit(action_t act, logic [STEP_W-1:0] xs, logic [STEP_W-1:0] ys);
			plot_action_t a;
			a.act = act;
			a.xs = xs;
			a.ys = ys;
			a.lift = cur_lift;
			a.line = line_count + 16'd1;
			expected_actions.push_back(a);
		endfunction

		function longint feed_digit(longint acc, logic [CHAR_W-1:0] c);
			longint v;
			v = acc;
			if (flags[NF_END])
				return v;
			if (c >= CH_0 && c <= CH_9) begin
				if (!flags[NF_FRAC]) begin
					v = v * 10 + longint'(c - CH_0);
					if (v > COORD_MAG)
						v = COORD_MAG;
				end
				flags[NF_DIG] = 1'b1;
			end else if (c == CH_MINUS || c == CH_PLUS) begin
				// A sign counts only as the very first character of a number.
				if (flags[NF_DIG] || flags[NF_NEG] || flags[NF_FRAC])
					flags[NF_END] = 1'b1;
				else if (c == CH_MINUS)
					flags[NF_NEG] = 1'b1;
			end else if (c == CH_DOT) begin
				if (flags[NF_FRAC])
					flags[NF_END] = 1'b1;
				else
					flags[NF_FRAC] = 1'b1;
			end else begin
				flags[NF_END] = 1'b1;
			end
			return v;
		endfunction

		function longint finish_value(longint mag);
			if (flags[NF_NEG])
				return -mag;
			return (mag > COORD_MAG - 1) ? COORD_MAG - 1 : mag;
		endfunction

		function logic [STEP_W-1:0] to_steps(longint v);
			longint unsigned m, p, lim;
			logic [STEP_W-1:0] r;
			m = (v < 0) ? -v : v;
			p = (m * feed_scale) >> 16;
			lim = 64'd1 << (STEP_W - 1);
			if (v < 0) begin
				if (p > lim)
					p = lim;
				r = STEP_W'(64'd0 - p);
			end else begin
				if (p > lim - 1)
					p = lim - 1;
				r = STEP_W'(p);
			end
			return r;
		endfunction

		function void complete_command();
			longint xv, yv;
			if (phase == PH_ARG_START) begin
				if (cmd == CMD_PU) begin
					if (!pen_up) begin
						pen_up = 1'b1;
						emit(ACT_RAISE, '0, '0);
					end
				end else if (cmd == CMD_PD) begin
					if (pen_up) begin
						pen_up = 1'b0;
						emit(ACT_LOWER, '0, '0);
					end
				end else begin
					emit(ACT_LINE, last_x, last_y);
				end
				return;
			end
			if (phase == PH_X_NUM) begin
				xv = finish_value(x_acc);
				yv = 0;
			end else begin
				xv = x_acc;
				yv = finish_value(y_acc);
			end
			last_x = to_steps(xv);
			last_y = to_steps(yv);
			if (cmd == CMD_PU)
				emit(ACT_MOVE, last_x, last_y);
			else
				emit(ACT_LINE, last_x, last_y);
		endfunction

		function void note_byte(logic [CHAR_W-1:0] c);
			bytes_seen++;
			if (c == CH_LF || c == CH_CR) begin
				if (phase == PH_ARG_START || phase == PH_X_NUM || phase == PH_Y_NUM)
					complete_command();
				// A line feed right after a carriage return belongs to the same line end.
				if (!(c == CH_LF && phase == PH_CMD && held == CH_CR))
					line_count = line_count + 16'd1;
				phase = PH_CMD;
				held = (c == CH_CR) ? CH_CR : 8'h00;
				return;
			end
			case (phase)
			PH_LETTER2: begin
				cmd = CMD_NONE;
				if (held == CH_I && c == CH_N) cmd = CMD_IN;
				else if (held == CH_S && c == CH_P) cmd = CMD_SP;
				else if (held == CH_P && c == CH_U) cmd = CMD_PU;
				else if (held == CH_P && c == CH_D) cmd = CMD_PD;
				else if (held == CH_P && c == CH_A) cmd = CMD_PA;
				else if (held == CH_L && c == CH_T) cmd = CMD_LT;
				if (cmd == CMD_NONE) begin
					if (first_letter(c)) begin
						held = c;
					end else begin
						held = 8'h00;
						phase = PH_CMD;
					end
				end else if (cmd == CMD_SP) begin
					phase = PH_SP_ARG;
				end else if (cmd == CMD_PU || cmd == CMD_PD || cmd == CMD_PA) begin
					phase = PH_ARG_START;
					x_acc = 0;
					y_acc = 0;
					flags = '0;
				end else begin
					phase = PH_CMD;
				end
			end
			PH_SP_ARG: begin
				if (c == CH_0)
					emit(ACT_HOME, '0, '0);
				else if (c >= CH_1 && c <= CH_8)
					cur_lift = pen_lift;
				phase = PH_CMD;
			end
			PH_ARG_START: begin
				if (c == CH_SEMI) begin
					complete_command();
					phase = PH_CMD;
				end else if ((c >= CH_0 && c <= CH_9) || c == CH_MINUS || c == CH_PLUS
					|| c == CH_DOT) begin
					phase = PH_X_NUM;
					x_acc = feed_digit(x_acc, c);
				end
			end
			PH_X_NUM: begin
				if (c == CH_SEMI) begin
					complete_command();
					phase = PH_CMD;
				end else if (c == CH_SPACE || c == CH_COMMA) begin
					x_acc = finish_value(x_acc);
					flags = '0;
					y_acc = 0;
					phase = PH_Y_NUM;
				end else begin
					x_acc = feed_digit(x_acc, c);
				end
			end
			PH_Y_NUM: begin
				if (c == CH_SEMI) begin
					complete_command();
					phase = PH_CMD;
				end else if (!(c == CH_SPACE && flags == 4'd0)) begin
					y_acc = feed_digit(y_acc, c);
				end
			end
			default: begin
				if (first_letter(c)) begin
					held = c;
					phase = PH_LETTER2;
				end else begin
					held = 8'h00;
					phase = PH_CMD;
				end
			end
			endcase
		endfunction

		function void report(string field, longint want_v, longint got_v);
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
			errors++;
		endfunction

		function void check_action(logic [ACT_W-1:0] act, logic [STEP_W-1:0] xs,
			logic [STEP_W-1:0] ys, logic [LIFT_W-1:0] lift, logic [LINE_W-1:0] line);
			plot_action_t want;
			actions_seen++;
			if (expected_actions.size() == 0) begin
				$display("%0t: unexpected action %0d x=%0d y=%0d lift=%0d line=%0d", $time,
					act, $signed(xs), $signed(ys), lift, line);
				errors++;
				return;
			end
			want = expected_actions.pop_front();
			if (want.act <= 4)
				act_count[want.act]++;
			if (act !== want.act) report("action", longint'(want.act), longint'(act));
			if (xs !== want.xs)
				report("x_steps", longint'($signed(want.xs)), longint'($signed(xs)));
			if (ys !== want.ys)
				report("y_steps", longint'($signed(want.ys)), longint'($signed(ys)));
			if (lift !== want.lift) report("lift_height", longint'(want.lift), longint'(lift));
			if (line !== want.line) report("line_number", longint'(want.line), longint'(line));
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write_en;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [SCALE_W-1:0]     cfg_wdata;
	logic                   in_valid;
	logic                   in_ready;
	logic [CHAR_W-1:0]      char_code;
	logic                   out_valid;
	logic                   out_ready;
	logic [ACT_W-1:0]       action;
	logic signed [STEP_W-1:0] x_steps;
	logic signed [STEP_W-1:0] y_steps;
	logic [LIFT_W-1:0]      lift_height;
	logic [LINE_W-1:0]      line_number;

	plot_action_checker sb;
	logic [CHAR_W-1:0]  byte_q[$];
	int                 burst_left;
	int                 idle_cycles = 0;
	int                 settings_used;

	hpgl_command_interpreter u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_code   (char_code),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.action      (action),
		.x_steps     (x_steps),
		.y_steps     (y_steps),
		.lift_height (lift_height),
		.line_number (line_number)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: segments of steady, random, periodic and long stalling ready.
	initial begin : receiver
		int mode, len, period, duty, i;
		out_ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			len = $urandom_range(8, 64);
			period = $urandom_range(2, 8);
			duty = $urandom_range(1, period - 1);
			for (i = 0; i < len; i++) begin
				@(negedge clk);
				case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ((i % period) < duty);
				default: out_ready <= (i >= duty * 3);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_action(action, x_steps, y_steps, lift_height, line_number);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d actions outstanding", $time,
					idle_cycles, sb.pending());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	function automatic void push_byte(logic [CHAR_W-1:0] b);
		byte_q.push_back(b);
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++)
			byte_q.push_back(s[i]);
	endfunction

	function automatic void push_digit();
		push_byte(CH_0 + CHAR_W'($urandom_range(0, 9)));
	endfunction

	function automatic void push_number();
		int kind, nd;
		kind = $urandom_range(0, 11);
		if (kind < 3)
			push_byte(CH_MINUS);
		else if (kind == 3)
			push_byte(CH_PLUS);
		// Long digit strings drive the value into saturation.
		if (kind == 0 || kind == 4)
			nd = $urandom_range(5, 7);
		else
			nd = $urandom_range(0, 4);
		repeat (nd) push_digit();
		if ($urandom_range(0, 4) == 0) begin
			push_byte(CH_DOT);
			repeat ($urandom_range(0, 3)) push_digit();
		end
		if (kind == 11) begin
			case ($urandom_range(0, 3))
			0: push_byte(CH_MINUS);
			1: push_byte(CH_PLUS);
			2: push_byte(CH_DOT);
			default: push_text("Q");
			endcase
			repeat ($urandom_range(0, 2)) push_digit();
		end
	endfunction

	function automatic void push_pen_mnemonic();
		case ($urandom_range(0, 2))
		0: push_text("PU");
		1: push_text("PD");
		default: push_text("PA");
		endcase
	endfunction

	function automatic void push_terminator();
		int k;
		k = $urandom_range(0, 19);
		if (k < 12) begin
			push_byte(CH_SEMI);
			if (k < 3)
				push_byte(CH_LF);
		end else if (k < 15) begin
			push_byte(CH_LF);
		end else if (k < 17) begin
			push_byte(CH_CR);
		end else begin
			push_byte(CH_CR);
			push_byte(CH_LF);
		end
	endfunction

	// Builds one command, mostly well formed, into byte_q. Returns the bytes that
	// count toward the stimulus length; plain noise counts as zero.
	function automatic int gen_command();
		int r, k;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			push_pen_mnemonic();
			k = $urandom_range(0, 9);
			if (k == 0)
				push_byte(CH_SPACE);
			else if (k == 1)
				push_byte(CH_COMMA);
			else if (k == 2)
				push_byte(CHAR_W'($urandom_range(0, 255)));
			push_number();
			// Now and then the Y value is left out.
			k = $urandom_range(0, 9);
			if (k != 0) begin
				push_byte((k < 5) ? CH_COMMA : CH_SPACE);
				repeat ($urandom_range(0, 2)) push_byte(CH_SPACE);
				push_number();
				if ($urandom_range(0, 7) == 0) begin
					push_byte(CH_COMMA);
					push_number();
					push_byte(CH_COMMA);
					push_number();
				end
			end
			push_terminator();
		end else if (r < 70) begin
			push_pen_mnemonic();
			push_terminator();
		end else if (r < 80) begin
			push_text("SP");
			k = $urandom_range(0, 9);
			if (k < 4)
				push_byte(CH_0);
			else if (k < 8)
				push_byte(CH_1 + CHAR_W'($urandom_range(0, 7)));
			else
				push_byte(CHAR_W'($urandom_range(0, 255)));
		end else if (r < 85) begin
			if (r < 83)
				push_text("IN");
			else
				push_text("LT");
			if ($urandom_range(0, 1))
				push_number();
			push_byte(CH_SEMI);
		end else if (r < 93) begin
			case ($urandom_range(0, 4))
			0: begin
				push_text("P");
				push_byte(CHAR_W'($urandom_range(8'h41, 8'h5A)));
			end
			1: begin
				if ($urandom_range(0, 1))
					push_text("S");
				else
					push_text("P");
				push_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
			end
			2: begin
				push_text("SP");
				push_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
			end
			3: begin
				push_text("PUx");
				push_number();
				push_byte(CH_COMMA);
				push_number();
				push_byte(CH_SEMI);
			end
			default: push_text("PA1-2,+.3.4;");
			endcase
		end else begin
			repeat ($urandom_range(1, 4)) push_byte(CHAR_W'($urandom_range(0, 255)));
			return 0;
		end
		return byte_q.size();
	endfunction

	// One transfer on the input channel, inside bursts separated by random gaps.
	task automatic send_byte(input logic [CHAR_W-1:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		char_code <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_byte(b);
		@(negedge clk);
	endtask

	task automatic send_queued();
		while (byte_q.size() > 0)
			send_byte(byte_q.pop_front());
	endtask

	// Lets every outstanding action drain and the pipeline empty.
	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [SCALE_W-1:0] value);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		sb.apply_config(idx, value);
		cfg_write_en <= 1'b0;
		@(negedge clk);
	endtask

	initial begin : stimulus
		logic [SCALE_W-1:0] scale;
		logic [LIFT_W-1:0]  il, pl;
		int counted;
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = CFG_FEED_SCALE;
		cfg_wdata = '0;
		in_valid = 1'b0;
		char_code = '0;
		burst_left = 0;
		settings_used = 1;
		sb = new();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: bare pen commands with and without a pen change, a bare PA
		// ended by a CR LF line end, home, the extreme bytes and saturating values.
		push_text("PU;PD;PA");
		push_byte(CH_CR);
		push_byte(CH_LF);
		push_text("SP0");
		push_byte(8'h00);
		push_byte(8'hFF);
		push_text("PD-99999,99999;");
		send_queued();

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p > 0) begin
				wait_idle();
				case (p)
				1: begin
					scale = '0;
					il = '0;
					pl = 16'hFFFF;
				end
				2: begin
					scale = 24'hFFFFFF;
					il = 16'hFFFF;
					pl = '0;
				end
				3: begin
					scale = 24'h010000;
					il = LIFT_W'($urandom_range(0, 16'hFFFF));
					pl = LIFT_W'($urandom_range(0, 16'hFFFF));
				end
				4: begin
					scale = SCALE_W'($urandom_range(0, 24'hFFFFFF));
					il = LIFT_W'($urandom_range(0, 16'hFFFF));
					pl = LIFT_W'($urandom_range(0, 16'hFFFF));
				end
				default: begin
					scale = FEED_SCALE_RESET;
					il = INIT_LIFT_RESET;
					pl = PEN_LIFT_RESET;
				end
				endcase
				write_reg(CFG_FEED_SCALE, scale);
				write_reg(CFG_INIT_LIFT, SCALE_W'(il));
				write_reg(CFG_PEN_LIFT, SCALE_W'(pl));
				settings_used++;
			end
			counted = 0;
			while (counted < PER_PHASE) begin
				counted += gen_command();
				send_queued();
			end
		end

		wait_idle();
		repeat (12) @(negedge clk);
		if (sb.pending() != 0)
			$display("%0t: %0d expected actions never arrived", $time, sb.pending());
		$display("Sent %0d bytes under %0d register settings; checked %0d actions.",
			sb.bytes_seen, settings_used, sb.actions_seen);
		$display("Actions by kind: move %0d, line %0d, raise %0d, lower %0d, home %0d.",
			sb.act_count[ACT_MOVE], sb.act_count[ACT_LINE], sb.act_count[ACT_RAISE],
			sb.act_count[ACT_LOWER], sb.act_count[ACT_HOME]);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
